>>> src/e2q_pkg.sv
package e2q_pkg;

  // Iteration count of the CORDIC rotation chain
  localparam int ITERS = 18;
  // Width of one input angle (Q3.14 radians)
  localparam int AW = 18;
  // Width of the CORDIC words (Q30, with headroom)
  localparam int CW = 33;
  // Width of the narrowed sine, cosine and pair products (Q20)
  localparam int NW = 22;
  // Width of a full product of two Q20 values (Q40)
  localparam int PW = 2 * NW;
  // Width of one quaternion component (Q16)
  localparam int QW = 18;
  // Number of angles handled side by side
  localparam int NANG = 3;

  localparam logic signed [CW-1:0] PI_Q30          = 33'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30     = 33'sd1686629713;
  localparam logic signed [CW-1:0] NEG_HALF_PI_Q30 = -33'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_X0       = 33'sd652032874;
  localparam logic signed [QW-1:0] ONE_Q16         = 18'sd65536;
  localparam logic signed [QW-1:0] NEG_ONE_Q16     = -18'sd65536;

  // Lane order inside the angle bus
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cord_lane_t;

  // Rotation state of all three angles plus the quadrant-fold negate flags
  typedef struct packed {
    cord_lane_t [NANG-1:0] lane;
    logic       [NANG-1:0] neg;
  } cord_bus_t;

  // Arctangent of 2^-i in Q30
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:    v = 33'sd843314856;
      5'd1:    v = 33'sd497837829;
      5'd2:    v = 33'sd263043836;
      5'd3:    v = 33'sd133525158;
      5'd4:    v = 33'sd67021686;
      5'd5:    v = 33'sd33543515;
      5'd6:    v = 33'sd16775850;
      5'd7:    v = 33'sd8388437;
      5'd8:    v = 33'sd4194282;
      5'd9:    v = 33'sd2097149;
      5'd10:   v = 33'sd1048575;
      5'd11:   v = 33'sd524287;
      5'd12:   v = 33'sd262143;
      5'd13:   v = 33'sd131071;
      5'd14:   v = 33'sd65535;
      5'd15:   v = 33'sd32767;
      5'd16:   v = 33'sd16383;
      5'd17:   v = 33'sd8191;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/e2q_fold.sv
module e2q_fold
  import e2q_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [NANG*AW-1:0]   up_angles,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output cord_bus_t            dn_bus
);

  logic                 valid_r, valid_nxt;
  logic                 adv;
  cord_bus_t            bus_r, bus_nxt;
  logic signed [CW-1:0] h;
  logic signed [CW:0]   h_dn;
  logic signed [CW:0]   h_up;

  assign adv      = !valid_r || dn_ready;
  assign up_ready = adv;

  // Half angle in Q30 is the raw Q3.14 value read as Q15, shifted up by 15.
  always_comb begin
    for (int a = 0; a < NANG; a++) begin
      h    = $signed({up_angles[a*AW +: AW], {(CW-AW){1'b0}}});
      h_dn = {h[CW-1], h} - {PI_Q30[CW-1], PI_Q30};
      h_up = {h[CW-1], h} + {PI_Q30[CW-1], PI_Q30};

      bus_nxt.lane[a].x = CORDIC_X0;
      bus_nxt.lane[a].y = '0;
      if (h > HALF_PI_Q30) begin
        bus_nxt.lane[a].z = h_dn[CW-1:0];
        bus_nxt.neg[a]    = 1'b1;
      end else if (h < NEG_HALF_PI_Q30) begin
        bus_nxt.lane[a].z = h_up[CW-1:0];
        bus_nxt.neg[a]    = 1'b1;
      end else begin
        bus_nxt.lane[a].z = h;
        bus_nxt.neg[a]    = 1'b0;
      end
    end
  end

  assign valid_nxt = adv ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      bus_r <= bus_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_bus   = bus_r;

endmodule

>>> src/e2q_cordic_cell.sv
module e2q_cordic_cell
  import e2q_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] iter_idx,
  input  logic       up_valid,
  output logic       up_ready,
  input  cord_bus_t  up_bus,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cord_bus_t  dn_bus
);

  logic                 valid_r, valid_nxt;
  logic                 adv;
  cord_bus_t            bus_r, bus_nxt;
  logic signed [CW-1:0] angle_step;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;

  assign adv        = !valid_r || dn_ready;
  assign up_ready   = adv;
  assign angle_step = atan_q30(iter_idx);

  // One micro-rotation per lane; iter_idx is tied to a constant per cell.
  always_comb begin
    bus_nxt.neg = up_bus.neg;
    for (int a = 0; a < NANG; a++) begin
      xs = $signed(up_bus.lane[a].x) >>> iter_idx;
      ys = $signed(up_bus.lane[a].y) >>> iter_idx;
      if (!up_bus.lane[a].z[CW-1]) begin
        bus_nxt.lane[a].x = $signed(up_bus.lane[a].x) - ys;
        bus_nxt.lane[a].y = $signed(up_bus.lane[a].y) + xs;
        bus_nxt.lane[a].z = $signed(up_bus.lane[a].z) - angle_step;
      end else begin
        bus_nxt.lane[a].x = $signed(up_bus.lane[a].x) + ys;
        bus_nxt.lane[a].y = $signed(up_bus.lane[a].y) - xs;
        bus_nxt.lane[a].z = $signed(up_bus.lane[a].z) + angle_step;
      end
    end
  end

  assign valid_nxt = adv ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      bus_r <= bus_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_bus   = bus_r;

endmodule

>>> src/e2q_combine.sv
module e2q_combine
  import e2q_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  cord_bus_t           up_bus,
  output logic                dn_valid,
  input  logic                dn_ready,
  output logic [4*QW-1:0]     dn_quat
);

  // Stage valids: a = narrowed sin/cos, b = pair products, c = full products,
  // d = rounded and clamped components.
  logic va_r, vb_r, vc_r, vd_r;
  logic adv_a, adv_b, adv_c, adv_d;

  logic signed [NW-1:0] cs_nxt [NANG];
  logic signed [NW-1:0] sn_nxt [NANG];
  logic signed [NW-1:0] cs_r   [NANG];
  logic signed [NW-1:0] sn_r   [NANG];

  logic signed [PW-1:0] cycp_f, sysp_f, sycp_f, cysp_f;
  logic signed [NW-1:0] cycp_nxt, sysp_nxt, sycp_nxt, cysp_nxt;
  logic signed [NW-1:0] cycp_r, sysp_r, sycp_r, cysp_r;
  logic signed [NW-1:0] sr_b_r, cr_b_r;

  // Eight Q40 terms, two per component
  logic signed [PW-1:0] term_nxt [8];
  logic signed [PW-1:0] term_r   [8];

  logic [4*QW-1:0] quat_nxt, quat_r;

  function automatic logic signed [NW-1:0] round_q20(input logic signed [PW-1:0] p);
    logic signed [PW:0] t;
    t = {p[PW-1], p} + (PW+1)'(1 << 19);
    return t[NW+19:20];
  endfunction

  function automatic logic [QW-1:0] finish(input logic signed [PW-1:0] p1,
                                           input logic signed [PW-1:0] p2);
    logic signed [PW+1:0] s;
    logic signed [PW+1:0] r;
    s = {{2{p1[PW-1]}}, p1} + {{2{p2[PW-1]}}, p2} + (PW+2)'(1 << 23);
    r = s >>> 24;
    if (r > $signed((PW+2)'(ONE_Q16))) begin
      return ONE_Q16;
    end else if (r < $signed({{(PW+2-QW){1'b1}}, NEG_ONE_Q16})) begin
      return NEG_ONE_Q16;
    end
    return r[QW-1:0];
  endfunction

  assign adv_d    = !vd_r || dn_ready;
  assign adv_c    = !vc_r || adv_d;
  assign adv_b    = !vb_r || adv_c;
  assign adv_a    = !va_r || adv_b;
  assign up_ready = adv_a;

  // Stage a: apply the fold negate and round Q30 down to Q20.
  for (genvar a = 0; a < NANG; a++) begin : g_narrow
    logic signed [CW:0] xn, yn;
    logic signed [CW:0] xr, yr;

    assign xn = up_bus.neg[a] ? -{up_bus.lane[a].x[CW-1], up_bus.lane[a].x}
                              :  {up_bus.lane[a].x[CW-1], up_bus.lane[a].x};
    assign yn = up_bus.neg[a] ? -{up_bus.lane[a].y[CW-1], up_bus.lane[a].y}
                              :  {up_bus.lane[a].y[CW-1], up_bus.lane[a].y};
    assign xr = xn + (CW+1)'(1 << 9);
    assign yr = yn + (CW+1)'(1 << 9);
    assign cs_nxt[a] = xr[NW+9:10];
    assign sn_nxt[a] = yr[NW+9:10];
  end

  // Stage b: yaw and pitch pair products.
  assign cycp_f = cs_r[LANE_YAW] * cs_r[LANE_PITCH];
  assign sysp_f = sn_r[LANE_YAW] * sn_r[LANE_PITCH];
  assign sycp_f = sn_r[LANE_YAW] * cs_r[LANE_PITCH];
  assign cysp_f = cs_r[LANE_YAW] * sn_r[LANE_PITCH];
  assign cycp_nxt = round_q20(cycp_f);
  assign sysp_nxt = round_q20(sysp_f);
  assign sycp_nxt = round_q20(sycp_f);
  assign cysp_nxt = round_q20(cysp_f);

  // Stage c: pair products times the roll terms.
  assign term_nxt[0] = cycp_r * cr_b_r;
  assign term_nxt[1] = sysp_r * sr_b_r;
  assign term_nxt[2] = cycp_r * sr_b_r;
  assign term_nxt[3] = -(sysp_r * cr_b_r);
  assign term_nxt[4] = sycp_r * sr_b_r;
  assign term_nxt[5] = cysp_r * cr_b_r;
  assign term_nxt[6] = sycp_r * cr_b_r;
  assign term_nxt[7] = -(cysp_r * sr_b_r);

  // Stage d: sum, round to Q16 and clamp.
  for (genvar q = 0; q < 4; q++) begin : g_finish
    assign quat_nxt[q*QW +: QW] = finish(term_r[2*q], term_r[2*q+1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (adv_a) begin
        va_r <= up_valid;
      end
      if (adv_b) begin
        vb_r <= va_r;
      end
      if (adv_c) begin
        vc_r <= vb_r;
      end
      if (adv_d) begin
        vd_r <= vc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && up_valid) begin
      cs_r <= cs_nxt;
      sn_r <= sn_nxt;
    end
    if (adv_b && va_r) begin
      cycp_r <= cycp_nxt;
      sysp_r <= sysp_nxt;
      sycp_r <= sycp_nxt;
      cysp_r <= cysp_nxt;
      sr_b_r <= sn_r[LANE_ROLL];
      cr_b_r <= cs_r[LANE_ROLL];
    end
    if (adv_c && vb_r) begin
      term_r <= term_nxt;
    end
    if (adv_d && vc_r) begin
      quat_r <= quat_nxt;
    end
  end

  assign dn_valid = vd_r;
  assign dn_quat  = quat_r;

endmodule

>>> src/euler_to_quaternion.sv
// Channel  | Direction | tdata fields (low bit first)               | tuser / tlast
// ---------+-----------+--------------------------------------------+--------------
// in_      | input     | roll_angle, pitch_angle, yaw_angle (18 b)  | none
// out_     | output    | quat_w, quat_x, quat_y, quat_z (18 b each) | none
//
// The pipeline has one quadrant-fold stage, 18 CORDIC cells, and four
// product and rounding stages, the last of which is the output register.
// One item is accepted every cycle unless a stall holds in_tready low; every
// stage moves on its own, so an output stall fills empty stages before in_tready drops.
// Reset (rst_n low at a clock edge) empties every stage; no state survives
// between items, so reset leaves nothing else to clear.
module euler_to_quaternion
  import e2q_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // roll_angle [17:0], pitch_angle [35:18], yaw_angle [53:36], zero [55:54]
  input  logic [55:0]          in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // quat_w [17:0], quat_x [35:18], quat_y [53:36], quat_z [71:54]
  output logic [4*QW-1:0]      out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready
);

  // Stage bus of the CORDIC chain: entry 0 is the fold output, entry i+1
  // is the output of cell i.
  cord_bus_t        chain_bus   [ITERS+1];
  logic [ITERS:0]   chain_valid;
  logic [ITERS:0]   chain_ready;

  // The fold stage halves each angle into Q30 and brings it into the
  // CORDIC range, remembering whether sine and cosine must be negated.
  e2q_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .up_angles (in_tdata[NANG*AW-1:0]),
    .dn_valid  (chain_valid[0]),
    .dn_ready  (chain_ready[0]),
    .dn_bus    (chain_bus[0])
  );

  // Each cell performs one micro-rotation on all three angles at once.
  for (genvar i = 0; i < ITERS; i++) begin : g_cell
    e2q_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .iter_idx (5'(i)),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_bus   (chain_bus[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_bus   (chain_bus[i+1])
    );
  end

  // Sine and cosine narrowing, the ZYX products and output clamping.
  e2q_combine u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_valid[ITERS]),
    .up_ready (chain_ready[ITERS]),
    .up_bus   (chain_bus[ITERS]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_quat  (out_tdata)
  );

`ifndef ASSERT_OFF
  // A ready sink must never hold back the source: every stage can advance.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");

  // Clamping keeps every component within -1..+1.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata[QW-1:0]) <= ONE_Q16) &&
      ($signed(out_tdata[QW-1:0]) >= NEG_ONE_Q16) &&
      ($signed(out_tdata[2*QW-1:QW]) <= ONE_Q16) &&
      ($signed(out_tdata[2*QW-1:QW]) >= NEG_ONE_Q16) &&
      ($signed(out_tdata[3*QW-1:2*QW]) <= ONE_Q16) &&
      ($signed(out_tdata[3*QW-1:2*QW]) >= NEG_ONE_Q16) &&
      ($signed(out_tdata[4*QW-1:3*QW]) <= ONE_Q16) &&
      ($signed(out_tdata[4*QW-1:3*QW]) >= NEG_ONE_Q16))
    else $error("quaternion component outside -1..+1");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !chain_valid[0])
    else $error("pipeline not empty after reset");
`endif

endmodule

>>> test/quat_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the Euler-to-quaternion converter. It predicts each
// quaternion from the accepted angle triple and compares it with the result
// items in order.
module quat_checker
  import e2q_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [55:0]       in_tdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [4*QW-1:0]   out_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  output int                mismatches,
  output int                outstanding
);

  typedef struct packed {
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] w;
  } quat_t;

  // Arctangent of 2^-i in Q30.
  localparam longint ARCTAN_Q30 [18] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191
  };
  localparam longint ROT_PI      = 64'sd3373259426;
  localparam longint ROT_HALF_PI = 64'sd1686629713;
  localparam longint ROT_START_X = 64'sd652032874;
  localparam longint UNIT_Q16    = 64'sd65536;

  quat_t expected_quats[$];

  function automatic longint round_shr(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // Sine and cosine of half the angle, Q20.
  function automatic void half_sin_cos(input logic signed [AW-1:0] angle,
                                       output longint sin_q20,
                                       output longint cos_q20);
    longint h, rx, ry, nx;
    bit flip;
    h = longint'(angle) * 32768;
    flip = 1'b0;
    if (h > ROT_HALF_PI) begin
      h -= ROT_PI;
      flip = 1'b1;
    end else if (h < -ROT_HALF_PI) begin
      h += ROT_PI;
      flip = 1'b1;
    end
    rx = ROT_START_X;
    ry = 0;
    for (int i = 0; i < 18; i++) begin
      if (h >= 0) begin
        nx = rx - (ry >>> i);
        ry = ry + (rx >>> i);
        h -= ARCTAN_Q30[i];
      end else begin
        nx = rx + (ry >>> i);
        ry = ry - (rx >>> i);
        h += ARCTAN_Q30[i];
      end
      rx = nx;
    end
    if (flip) begin
      rx = -rx;
      ry = -ry;
    end
    cos_q20 = round_shr(rx, 10);
    sin_q20 = round_shr(ry, 10);
  endfunction

  function automatic logic signed [QW-1:0] clamp_q16(input longint acc);
    longint v;
    v = round_shr(acc, 24);
    if (v > UNIT_Q16) v = UNIT_Q16;
    if (v < -UNIT_Q16) v = -UNIT_Q16;
    return v[QW-1:0];
  endfunction

  function automatic quat_t predict_quat(input logic [55:0] angles);
    longint sr, cr, sp, cp, sy, cy;
    longint cycp, sysp, sycp, cysp;
    quat_t q;
    half_sin_cos(angles[17:0], sr, cr);
    half_sin_cos(angles[35:18], sp, cp);
    half_sin_cos(angles[53:36], sy, cy);
    cycp = round_shr(cy * cp, 20);
    sysp = round_shr(sy * sp, 20);
    sycp = round_shr(sy * cp, 20);
    cysp = round_shr(cy * sp, 20);
    q.w = clamp_q16(cycp * cr + sysp * sr);
    q.x = clamp_q16(cycp * sr - sysp * cr);
    q.y = clamp_q16(sycp * sr + cysp * cr);
    q.z = clamp_q16(sycp * cr - cysp * sr);
    return q;
  endfunction

  task automatic check_component(input string label, input logic signed [QW-1:0] want,
                                 input logic signed [QW-1:0] got);
    if (want !== got) begin
      $display("%0t: quat_%s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    quat_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_quats.push_back(predict_quat(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_quats.pop_front();
          check_component("w", want.w, out_tdata[17:0]);
          check_component("x", want.x, out_tdata[35:18]);
          check_component("y", want.y, out_tdata[53:36]);
          check_component("z", want.z, out_tdata[71:54]);
        end
      end
    end
    outstanding = expected_quats.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the Euler-to-quaternion converter. The angle
// triples are driven at the falling edge; the checker beside the block does
// all prediction and comparison and reports its failure count back here.
module testbench;
  import e2q_pkg::*;

  // The run is far shorter than this; it only catches a hang.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;
  // The final stretch of items runs with no idling on either side.
  localparam int QUIET_TAIL   = 100;
  // Longer than the pipeline depth, to catch stray result items.
  localparam int DRAIN_CYCLES = 40;
  // Pi in Q3.14: above this magnitude the quadrant fold kicks in.
  localparam int FOLD_EDGE    = 51472;

  logic              clk = 1'b0;
  logic              rst_n;
  logic [55:0]       in_tdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [4*QW-1:0]   out_tdata;
  logic              out_tvalid;
  logic              out_tready;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  // Percent chance per item (sender) or per cycle (receiver) of an idle burst.
  int tx_odds;
  int rx_odds;
  int rx_stall_left = 0;

  always #10 clk = ~clk;

  euler_to_quaternion uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  quat_checker quat_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Hang guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver drops out_tready in idle bursts of random length. With rx_odds
  // at zero it stays ready once any running burst has ended.
  always @(negedge clk) begin
    if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else if (rx_odds != 0 && $urandom_range(1, 100) <= rx_odds) begin
      out_tready <= 1'b0;
      rx_stall_left = $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Random angles lean on the interesting regions: around the quadrant fold
  // and around half of it on either side, near zero, and the range extremes.
  // About half are uniform over all 18-bit patterns, so every bit toggles.
  function automatic logic [AW-1:0] pick_angle();
    int pick;
    logic [AW-1:0] a;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      a = AW'($urandom);
    end else if (pick < 7) begin
      a = AW'(FOLD_EDGE + $urandom_range(0, 6) - 3);
      if ($urandom_range(0, 1)) a = -a;
    end else if (pick == 7) begin
      a = AW'($urandom_range(0, 4000) - 2000);
    end else if (pick == 8) begin
      a = AW'(FOLD_EDGE / 2 + $urandom_range(0, 8) - 4);
      if ($urandom_range(0, 1)) a = -a;
    end else begin
      case ($urandom_range(0, 3))
        0:       a = 18'h1FFFF;
        1:       a = 18'h20000;
        2:       a = 18'h00000;
        default: a = 18'h3FFFF;
      endcase
    end
    return a;
  endfunction

  // Sends one angle triple. Called at a falling edge; returns at the falling
  // edge after the item was taken. An idle burst, if any, comes first, so
  // in_tvalid is never lowered and raised within the same time step.
  task automatic send_angles(input logic [AW-1:0] roll, input logic [AW-1:0] pitch,
                             input logic [AW-1:0] yaw);
    if (tx_odds != 0 && $urandom_range(1, 100) <= tx_odds) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tdata  <= {2'b00, yaw, pitch, roll};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    tx_odds    = 0;
    rx_odds    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items, with light idling on both sides.
    tx_odds = 25;
    rx_odds = 25;
    // All angles zero: the identity quaternion, w right at the clamp.
    send_angles(18'sd0, 18'sd0, 18'sd0);
    // Extremes of the input range, alone and mixed.
    send_angles(18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
    send_angles(18'h20000, 18'h20000, 18'h20000);
    send_angles(18'h1FFFF, 18'h20000, 18'sd0);
    send_angles(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    // Just inside and just past the quadrant fold, both signs.
    send_angles(18'sd51471, 18'sd51472, -18'sd51472);
    send_angles(-18'sd51471, 18'sd51473, 18'sd51471);
    // A half-turn on a single axis drives one vector part to the clamp.
    send_angles(18'sd51472, 18'sd0, 18'sd0);
    send_angles(18'sd0, 18'sd51472, 18'sd0);
    send_angles(18'sd0, 18'sd0, -18'sd51472);
    // Pitch at a quarter turn: the gimbal-lock attitude.
    send_angles(18'sd51472, 18'sd25736, 18'sd51472);
    send_angles(18'sd12868, -18'sd12868, 18'sd12868);
    send_angles(18'sd1, 18'sd2, 18'sd4);
    // Alternating bit patterns.
    send_angles(18'h15555, 18'h2AAAA, 18'h0F0F0);
    send_angles(18'h2AAAA, 18'h15555, 18'h30F0F);

    // Hold the sender off until every directed result has come back.
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);

    // Random items. The idling mix changes every 60 items, and some
    // stretches have none at all; the tail always runs at full rate.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
        tx_odds = 0;
        rx_odds = 0;
      end else if (n % 60 == 0) begin
        case ($urandom_range(0, 3))
          0:       tx_odds = 0;
          1:       tx_odds = 10;
          2:       tx_odds = 35;
          default: tx_odds = 70;
        endcase
        case ($urandom_range(0, 3))
          0:       rx_odds = 0;
          1:       rx_odds = 5;
          2:       rx_odds = 20;
          default: rx_odds = 50;
        endcase
      end
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    in_tvalid <= 1'b0;

    // Wait for every expected result, then watch a while for stray items.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
